>>> rtl/arps_pkg.sv
// Shared types and constants for the audio RMS peak strobe.
// No dependencies; imported by every module of the block.
package arps_pkg;

  localparam int FRAME_MAX = 1024;
  localparam int CNT_W     = $clog2(FRAME_MAX + 1);
  localparam int SUM_W     = 42;
  localparam int LOG_W     = 22;
  localparam int METRIC_W  = 24;
  localparam int QDEPTH    = 2;

  // round(2^32 / (10*log10 2))
  localparam logic [31:0]         LOG_SCALE  = 32'd1426757253;
  localparam logic [METRIC_W-1:0] METRIC_MAX = '1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic       peak_hit;
    logic       quiet;
  } out_item_t;

  // One finished frame handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic [15:0]         peak_ratio;
    logic [7:0]          fade_factor;
    logic [METRIC_W-1:0] silence_level;
    logic [15:0]         bias_decay;
    logic [8:0]          brightness_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_PEAK_RATIO  = 3'd0,
    CFG_FADE_FACTOR = 3'd1,
    CFG_SILENCE     = 3'd2,
    CFG_BIAS_DECAY  = 3'd3,
    CFG_GAIN        = 3'd4
  } cfg_idx_t;

endpackage

>>> rtl/arps_front.sv
// Front end: squares samples and accumulates the frame sum and count.
// Depends on arps_pkg; pushes one job per frame into arps_jobq.
module arps_front import arps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  in_item_t   in_item,
  output logic       in_full,
  input  logic [1:0] q_cnt,
  output logic       job_push,
  output job_t       job
);

  logic             v_r;
  logic             last_r;
  logic [30:0]      sq_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] count_r;

  logic              in_acc;
  logic [1:0]        pending;
  logic signed [31:0] sq_full;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic              frame_end;

  // room check counts the item still in the square stage
  assign pending = 2'(q_cnt + {1'b0, v_r});
  assign in_full = (pending >= 2'(QDEPTH));
  assign in_acc  = in_push & ~in_full;

  assign sq_full = in_item.sample * in_item.sample;

  // square stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_acc;
    end
    if (in_acc) begin
      sq_r   <= sq_full[30:0];
      last_r <= in_item.last_in_frame;
    end
  end

  // saturating accumulate and frame end
  always_comb begin
    sum_wide  = {1'b0, sum_r} + (SUM_W + 1)'(sq_r);
    sum_nxt   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    count_nxt = count_r + CNT_W'(1);
    frame_end = last_r | (count_nxt >= CNT_W'(FRAME_MAX));
  end

  assign job_push  = v_r & frame_end;
  assign job.sum   = sum_nxt;
  assign job.count = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (v_r) begin
      if (frame_end) begin
        sum_r   <= '0;
        count_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

>>> rtl/arps_jobq.sv
// Two-entry queue of finished frames between front and back.
// Depends on arps_pkg for the job type.
module arps_jobq import arps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       din,
  input  logic       pop,
  output job_t       dout,
  output logic [1:0] cnt,
  output logic       empty
);

  job_t       mem_r [QDEPTH];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign cnt   = cnt_r;
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'(QDEPTH) || pop)) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("job queue underflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("job count slip");
`endif

endmodule

>>> rtl/arps_back.sv
// Back end: log2, reciprocal metric, peak/fade decision and result queue.
// Depends on arps_pkg; takes jobs from arps_jobq and config from the top.
module arps_back import arps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      job_empty,
  input  job_t      job,
  output logic      job_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_NORM = 9'b000000010,
    S_SQR  = 9'b000000100,
    S_PREP = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_DEC1 = 9'b000100000,
    S_DEC2 = 9'b001000000,
    S_DEC3 = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t state_r;

  logic [42:0]         norm_r;
  logic [5:0]          k_r;
  logic [31:0]         m_r;
  logic [3:0]          i_r;
  logic [15:0]         frac_r;
  logic                phase_r;
  logic [LOG_W-1:0]    loga_r;
  logic [LOG_W-1:0]    logb_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [22:0]         lq_r;
  logic [22:0]         rem_r;
  logic [31:0]         quo_r;
  logic [4:0]          dstep_r;
  logic [METRIC_W-1:0] metric_r;
  logic signed [24:0]  delta_r;
  logic signed [48:0]  prod_r;
  logic signed [41:0]  dec_r;
  logic signed [31:0]  lc_r;
  logic [METRIC_W-1:0] pm_r;
  logic [7:0]          pb_r;
  logic [7:0]          bright_r;
  logic                peak_r;
  logic                quiet_r;

  out_item_t oq_r [QDEPTH];
  logic      owp_r;
  logic      orp_r;
  logic [1:0] ocnt_r;

  logic [63:0]        sq64;
  logic [32:0]        t;
  logic [15:0]        frac_nxt;
  logic signed [23:0] lsum;
  logic [23:0]        labs;
  logic [23:0]        rem_sh;
  logic               ge;
  logic [23:0]        rem_sub;
  logic [31:0]        quo_nxt;
  logic               peak;
  logic [15:0]        fade_p;
  logic signed [17:0] dsh;
  logic signed [32:0] lc_diff;
  logic signed [31:0] lc_sat;
  logic [16:0]        gain_p;
  logic [7:0]         gained;
  logic               out_push;
  logic               out_do_pop;

  // datapath helpers
  always_comb begin
    sq64     = m_r * m_r;
    t        = sq64[63:31];
    frac_nxt = {frac_r[14:0], t[32]};
    lsum     = $signed({2'b0, loga_r}) - $signed({2'b0, logb_r}) - 24'sd1966080;
    labs     = lsum[23] ? 24'(-lsum) : 24'(lsum);
    rem_sh   = {rem_r, quo_r[31]};
    ge       = rem_sh >= {1'b0, lq_r};
    rem_sub  = rem_sh - {1'b0, lq_r};
    quo_nxt  = {quo_r[30:0], ge};
    peak     = $signed({delta_r, 16'b0}) >= prod_r;
    fade_p   = cfg.fade_factor * pb_r;
    dsh      = dec_r[41:24];
    lc_diff  = $signed({lc_r[31], lc_r}) - $signed({{15{dsh[17]}}, dsh});
    if (lc_diff > 33'sd2147483647)       lc_sat = 32'sh7fffffff;
    else if (lc_diff < -33'sd2147483648) lc_sat = 32'sh80000000;
    else                                  lc_sat = lc_diff[31:0];
    gain_p   = bright_r * cfg.brightness_gain;
    gained   = gain_p[16] ? 8'hff : gain_p[15:8];
  end

  assign job_pop    = (state_r == S_IDLE) & ~job_empty;
  assign out_push   = (state_r == S_EMIT) & (ocnt_r != 2'(QDEPTH));
  assign out_do_pop = out_pop & ~out_empty;

  // frame-end sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pm_r    <= '0;
      pb_r    <= '0;
      lc_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            cnt_r <= job.count;
            if (job.sum == '0) begin
              pb_r <= '0;
              lc_r <= '0;
            end else begin
              norm_r  <= {job.sum, 1'b0};
              k_r     <= 6'd42;
              phase_r <= 1'b0;
              state_r <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (norm_r[42]) begin
            m_r     <= norm_r[42:11];
            i_r     <= '0;
            frac_r  <= '0;
            state_r <= S_SQR;
          end else begin
            norm_r <= {norm_r[41:0], 1'b0};
            k_r    <= k_r - 6'd1;
          end
        end
        S_SQR: begin
          m_r    <= t[32] ? t[32:1] : t[31:0];
          frac_r <= frac_nxt;
          i_r    <= i_r + 4'd1;
          if (i_r == 4'd15) begin
            if (!phase_r) begin
              loga_r  <= {k_r, frac_nxt};
              norm_r  <= 43'(cnt_r);
              k_r     <= 6'd42;
              phase_r <= 1'b1;
              state_r <= S_NORM;
            end else begin
              logb_r  <= {k_r, frac_nxt};
              state_r <= S_PREP;
            end
          end
        end
        S_PREP: begin
          lq_r <= labs[22:0];
          if (labs == '0) begin
            metric_r <= METRIC_MAX;
            state_r  <= S_DEC1;
          end else begin
            rem_r   <= '0;
            quo_r   <= LOG_SCALE;
            dstep_r <= 5'd31;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r   <= ge ? rem_sub[22:0] : rem_sh[22:0];
          quo_r   <= quo_nxt;
          dstep_r <= dstep_r - 5'd1;
          if (dstep_r == 5'd0) begin
            metric_r <= (|quo_nxt[31:24]) ? METRIC_MAX : quo_nxt[23:0];
            state_r  <= S_DEC1;
          end
        end
        S_DEC1: begin
          if (metric_r < cfg.silence_level) begin
            bright_r <= '0;
            peak_r   <= 1'b0;
            quiet_r  <= 1'b1;
            pb_r     <= '0;
            pm_r     <= metric_r;
            state_r  <= S_EMIT;
          end else begin
            delta_r <= $signed({1'b0, metric_r}) - $signed({1'b0, pm_r});
            prod_r  <= lc_r * $signed({1'b0, cfg.peak_ratio});
            quiet_r <= 1'b0;
            state_r <= S_DEC2;
          end
        end
        S_DEC2: begin
          peak_r <= peak;
          if (peak) begin
            lc_r     <= 32'(delta_r);
            bright_r <= 8'hff;
          end else begin
            bright_r <= fade_p[15:8];
          end
          dec_r   <= delta_r * $signed({1'b0, cfg.bias_decay});
          state_r <= S_DEC3;
        end
        S_DEC3: begin
          lc_r    <= lc_sat;
          pb_r    <= bright_r;
          pm_r    <= metric_r;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (ocnt_r != 2'(QDEPTH)) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (out_push) begin
      oq_r[owp_r] <= '{brightness: gained, peak_hit: peak_r, quiet: quiet_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (out_push)   owp_r <= ~owp_r;
      if (out_do_pop) orp_r <= ~orp_r;
      ocnt_r <= 2'(ocnt_r + {1'b0, out_push} - {1'b0, out_do_pop});
    end
  end

  assign out_empty = (ocnt_r == 2'd0);
  assign out_item  = oq_r[orp_r];

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> lq_r != '0) else $error("divide by zero");
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM && !norm_r[42]) |-> k_r != 6'd0) else $error("normalise ran out");
  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'(QDEPTH)) else $error("result queue overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> state_r == S_NORM || state_r == S_IDLE) else $error("job taken mid-frame");
`endif

endmodule

>>> rtl/audio_rms_peak_strobe_unit.sv
// Top level of the audio RMS peak strobe: configuration registers and wiring.
// Depends on arps_pkg, arps_front, arps_jobq and arps_back.
//
// Samples are taken one per clock while in_full is low; a two-entry frame
// queue holds finished frames. For each frame the back end takes the job,
// normalises the sum bit by bit and runs the shared 16-step log2 squaring
// loop, does the same for the count, then runs a prepare step, a restoring
// divide (skipped when the log difference is zero) and the decision states
// before it emits the result; a frame with a zero sum emits nothing. Frames
// that end faster than the back end finishes them back-pressure the input.
// Registers are written through cfg_index/cfg_data, always ready.
module audio_rms_peak_strobe_unit import arps_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  in_item_t        in_item,
  output logic            in_full,
  input  logic            out_pop,
  output logic            out_empty,
  output out_item_t       out_item,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [23:0]     cfg_data
);

  cfg_t       cfg_r;
  logic       job_push;
  job_t       job_in;
  job_t       job_out;
  logic       job_pop;
  logic [1:0] job_cnt;
  logic       job_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_ratio      <= 16'd32768;
      cfg_r.fade_factor     <= 8'd77;
      cfg_r.silence_level   <= 24'd655;
      cfg_r.bias_decay      <= 16'd1678;
      cfg_r.brightness_gain <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PEAK_RATIO:  cfg_r.peak_ratio      <= cfg_data[15:0];
        CFG_FADE_FACTOR: cfg_r.fade_factor     <= cfg_data[7:0];
        CFG_SILENCE:     cfg_r.silence_level   <= cfg_data;
        CFG_BIAS_DECAY:  cfg_r.bias_decay      <= cfg_data[15:0];
        CFG_GAIN:        cfg_r.brightness_gain <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  arps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .q_cnt    (job_cnt),
    .job_push (job_push),
    .job      (job_in)
  );

  arps_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_out),
    .cnt   (job_cnt),
    .empty (job_empty)
  );

  arps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

>>> dv/audio_rms_peak_strobe_checker.sv
// Checker for the audio RMS peak strobe: predicts the strobe results and
// compares them with what the block gives. Depends on arps_pkg.
module audio_rms_peak_strobe_checker import arps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_item,
  input  logic        in_full,
  input  logic        out_pop,
  input  logic        out_empty,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          errors,
  output int          pending
);

  // register copies
  logic [15:0] ratio_r;
  logic [7:0]  fade_r;
  logic [23:0] silence_r;
  logic [15:0] decay_r;
  logic [8:0]  gain_r;

  // frame and loudness state
  logic [63:0]        frame_sum;
  int                 frame_len;
  logic [23:0]        last_metric;
  logic signed [31:0] big_rise;
  logic [7:0]         last_glow;

  out_item_t strobe_q[$];

  assign pending = strobe_q.size();

  // log2 in Q.16 by repeated squaring of a 32-bit mantissa
  function automatic logic [31:0] log2_fix(logic [63:0] n);
    int          k;
    logic [63:0] m;
    logic [15:0] frac;
    k = 0;
    frac = '0;
    while (k < 63 && (n >> (k + 1)) != 0) k++;
    if (k >= 31) m = n >> (k - 31);
    else m = n << (31 - k);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[15 - i] = 1'b1;
      end
    end
    return {k[15:0], frac};
  endfunction

  // one sample in; at frame end, queue the strobe result unless the frame is silent
  task automatic take_sample(in_item_t it);
    longint     sq, lq, delta, dec, nrise;
    logic [63:0] quo;
    logic [23:0] metric;
    int         bright, gained;
    logic       peak, quiet;
    sq = longint'(it.sample) * longint'(it.sample);
    frame_sum = frame_sum + sq;
    if (frame_sum > 64'h3FF_FFFF_FFFF) frame_sum = 64'h3FF_FFFF_FFFF;
    frame_len++;
    if (!it.last_in_frame && frame_len < FRAME_MAX) return;
    if (frame_sum == 0) begin
      // silent frame: clear peak and glow, nothing emitted
      last_glow = '0;
      big_rise = '0;
      frame_len = 0;
      return;
    end
    lq = longint'(log2_fix(frame_sum * 2)) - longint'(log2_fix(64'(frame_len)))
       - (longint'(30) << 16);
    frame_sum = '0;
    frame_len = 0;
    if (lq < 0) lq = -lq;
    if (lq == 0) metric = '1;
    else begin
      quo = 64'(LOG_SCALE) / 64'(lq);
      metric = (quo > 64'hFF_FFFF) ? 24'hFF_FFFF : quo[23:0];
    end
    bright = 0;
    peak = 1'b0;
    quiet = 1'b0;
    if (metric < silence_r) quiet = 1'b1;
    else begin
      delta = longint'(metric) - longint'(last_metric);
      if (delta * 65536 >= longint'(big_rise) * longint'(ratio_r)) begin
        big_rise = delta[31:0];
        bright = 255;
        peak = 1'b1;
      end else if (last_glow != 0) begin
        bright = (int'(fade_r) * int'(last_glow)) >> 8;
      end
      dec = longint'(decay_r) * delta;
      if (dec >= 0) dec = dec >>> 24;
      else dec = -((-dec + 64'hFF_FFFF) >>> 24);
      nrise = longint'(big_rise) - dec;
      if (nrise > 64'sh7FFF_FFFF) nrise = 64'sh7FFF_FFFF;
      if (nrise < -64'sh8000_0000) nrise = -64'sh8000_0000;
      big_rise = nrise[31:0];
    end
    last_glow = bright[7:0];
    last_metric = metric;
    gained = (bright * int'(gain_r)) >> 8;
    if (gained > 255) gained = 255;
    strobe_q.push_back('{brightness: gained[7:0], peak_hit: peak, quiet: quiet});
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ratio_r <= 16'd32768;
      fade_r <= 8'd77;
      silence_r <= 24'd655;
      decay_r <= 16'd1678;
      gain_r <= 9'd256;
      frame_sum = '0;
      frame_len = 0;
      last_metric = '0;
      big_rise = '0;
      last_glow = '0;
      strobe_q.delete();
      errors <= 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PEAK_RATIO:  ratio_r <= cfg_data[15:0];
          CFG_FADE_FACTOR: fade_r <= cfg_data[7:0];
          CFG_SILENCE:     silence_r <= cfg_data;
          CFG_BIAS_DECAY:  decay_r <= cfg_data[15:0];
          CFG_GAIN:        gain_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      // result compare
      if (out_pop && !out_empty) begin
        if (strobe_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors <= errors + 1;
        end else begin
          want = strobe_q.pop_front();
          if (want.brightness !== out_item.brightness ||
              want.peak_hit !== out_item.peak_hit || want.quiet !== out_item.quiet) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
            errors <= errors + 1;
          end
        end
      end
      if (in_push && !in_full) take_sample(in_item);
    end
  end

endmodule

>>> dv/audio_rms_peak_strobe_unit_tb.sv
// Testbench top for the audio RMS peak strobe: clock, reset, stimulus, verdict.
// Depends on arps_pkg, audio_rms_peak_strobe_unit and audio_rms_peak_strobe_checker.
module audio_rms_peak_strobe_unit_tb;
  import arps_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 400;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  in_item_t    in_item;
  logic        in_full;
  logic        out_pop;
  logic        out_empty;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  int          errors;
  int          pending;
  int          quiet_cycles;
  int          burst_left;
  int          run_cycles;

  audio_rms_peak_strobe_unit dut (.*);
  audio_rms_peak_strobe_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  // receiver: changing stall pattern, one long hold-off early on
  initial begin
    int mode;
    out_pop = 1'b0;
    run_cycles = 0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      run_cycles++;
      if (run_cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (run_cycles >= 200 && run_cycles < 2700) out_pop <= 1'b0;
      else case (mode)
        0: out_pop <= 1'b1;
        1: out_pop <= ($urandom_range(0, 1) == 1);
        2: out_pop <= ($urandom_range(0, 7) == 0);
        default: out_pop <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // one sample, offered at the falling edge until taken
  task automatic send_sample(logic signed [15:0] s, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        in_push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    @(negedge clk);
    in_push <= 1'b1;
    in_item <= '{sample: s, last_in_frame: last};
    while (in_full) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold input until every result is out and the back end is quiet
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample(int level);
    case (level)
      0: return 16'sd0;
      1: return 16'($signed($urandom_range(0, 6)) - 3);
      2: return 16'($signed($urandom_range(0, 4000)) - 2000);
      3: return 16'($urandom);
      default: return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  task automatic send_frame(int len, int level);
    for (int i = 0; i < len; i++) send_sample(pick_sample(level), i == len - 1);
  endtask

  initial begin
    int sent, len, level;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed frames at reset settings
    send_frame(2, 0);                    // all-zero frame
    send_sample(16'sh8000, 1'b0);        // log of exactly zero
    send_sample(16'sd0, 1'b1);
    send_frame(1, 4);
    send_frame(3, 1);                    // quieter: fade
    send_frame(2, 1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_frame(4, 2);
    send_frame(2, 0);
    send_frame(3, 3);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_PEAK_RATIO, 24'hFFFF);
          write_reg(CFG_FADE_FACTOR, 24'hFF);
          write_reg(CFG_SILENCE, 24'hFF_FFFF);
          write_reg(CFG_BIAS_DECAY, 24'hFFFF);
          write_reg(CFG_GAIN, 24'd256);
        end
        1: begin
          write_reg(CFG_PEAK_RATIO, 24'd0);
          write_reg(CFG_FADE_FACTOR, 24'd0);
          write_reg(CFG_SILENCE, 24'd0);
          write_reg(CFG_BIAS_DECAY, 24'd0);
          write_reg(CFG_GAIN, 24'd0);
        end
        default: begin
          write_reg(CFG_PEAK_RATIO, 24'($urandom_range(0, 65535)));
          write_reg(CFG_FADE_FACTOR, 24'($urandom_range(0, 255)));
          write_reg(CFG_SILENCE, ($urandom_range(0, 7) == 0) ?
                    24'($urandom) : 24'($urandom_range(0, 30000)));
          write_reg(CFG_BIAS_DECAY, 24'($urandom_range(0, 65535)));
          write_reg(CFG_GAIN, 24'($urandom_range(0, 256)));
        end
      endcase
      sent = 0;
      while (sent < 30) begin
        level = $urandom_range(0, 15);
        level = (level == 0) ? 0 : (level < 3) ? 1 : (level < 6) ? 2 :
                (level < 14) ? 3 : 4;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
          6, 7: len = $urandom_range(7, 24);
          default: len = $urandom_range(25, 120);
        endcase
        send_frame(len, level);
        sent += len;
      end
      // an unmarked frame that ends at the length limit
      if (ph == 3) for (int i = 0; i < FRAME_MAX; i++) send_sample(pick_sample(3), 1'b0);
      drain();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
